// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the gradient corner color block.
// Depends on nothing; every assertion is clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GCC_ASSERT(lbl, prop, msg)
`define GCC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/gcc_pkg.sv -----
// Shared types, constants and helper functions of the gradient corner color block.
// Depends on nothing; used by the front end, the queue, the back end and the top level.
`timescale 1ns / 1ps
package gcc_pkg;

  localparam int DirW       = 16;
  localparam int ColorW     = 8;
  localparam int NumW       = DirW + 1;
  localparam int DivisorW   = 32;
  localparam int QuotW      = 18;
  localparam int DividendW  = 47;
  localparam int RootW      = 63;
  localparam int WeightW    = 17;
  localparam int QueueDepth = 2;

  localparam logic [WeightW-1:0] WeightHalf = 17'd32768;
  localparam logic [WeightW-1:0] WeightFull = 17'd65536;
  localparam logic [QuotW-1:0]   OffsetMax  = 18'd32768;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic signed [NumW-1:0] num_a;    // dx + dy, corner (-1,-1)
    logic signed [NumW-1:0] num_b;    // dy - dx, corner (1,-1)
    logic [DivisorW-1:0]    divisor;
    logic                   compressed;
    logic                   zero_dir;
    logic [ColorW-1:0]      s_red;
    logic [ColorW-1:0]      s_green;
    logic [ColorW-1:0]      s_blue;
    logic [ColorW-1:0]      s_alpha;
    logic [ColorW-1:0]      e_red;
    logic [ColorW-1:0]      e_green;
    logic [ColorW-1:0]      e_blue;
    logic [ColorW-1:0]      e_alpha;
  } gcc_item_t;

  // floor(a * op / 255), exact for every 16-bit product.
  function automatic logic [ColorW-1:0] scale_alpha(input logic [ColorW-1:0] a,
                                                     input logic [ColorW-1:0] op);
    logic [15:0] x;
    logic [16:0] s;
    x = a * op;
    s = {1'b0, x} + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ----- design/gcc_front.sv -----
// Front end: takes an input transfer, scales the alphas and finds the divisor
// (L1 norm or a bit-serial square root). Depends on gcc_pkg.
`timescale 1ns / 1ps
module gcc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             compressed_mode,
  input  logic signed [gcc_pkg::DirW-1:0]  in_dir_x,
  input  logic signed [gcc_pkg::DirW-1:0]  in_dir_y,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_red,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_green,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_blue,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_red,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_green,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_blue,
  input  logic [gcc_pkg::ColorW-1:0]       in_layer_opacity,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_alpha,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_alpha,
  output logic                             push_valid,
  input  logic                             push_ready,
  output gcc_pkg::gcc_item_t               push_item
);
  import gcc_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_ROOT = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic signed [DirW-1:0] dx_r, dy_r;
  logic [ColorW-1:0] sr_r, sg_r, sb_r, er_r, eg_r, eb_r, op_r, sa_r, ea_r;
  logic comp_r;
  logic [RootW-1:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt;

  logic signed [31:0] sq_x, sq_y;
  logic [31:0] sq_sum;
  logic [RootW-1:0] trial;
  logic signed [NumW-1:0] dx_e, dy_e, abs_x, abs_y;
  logic [NumW-1:0] l1;
  logic zero_dir;

  assign sq_x   = dx_r * dx_r;
  assign sq_y   = dy_r * dy_r;
  assign sq_sum = 32'(sq_x) + 32'(sq_y);
  assign trial  = res_r + bit_r;

  assign dx_e  = {dx_r[DirW-1], dx_r};
  assign dy_e  = {dy_r[DirW-1], dy_r};
  assign abs_x = dx_r[DirW-1] ? -dx_e : dx_e;
  assign abs_y = dy_r[DirW-1] ? -dy_e : dy_e;
  assign l1    = NumW'(abs_x) + NumW'(abs_y);
  assign zero_dir = (dx_r == '0) && (dy_r == '0);

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) state_nxt = F_SQ;
      end
      F_SQ: begin
        v_nxt   = {sq_sum, 31'b0};
        res_nxt = '0;
        bit_nxt = {1'b1, {(RootW-1){1'b0}}};
        state_nxt = (comp_r || zero_dir) ? F_PUSH : F_ROOT;
      end
      F_ROOT: begin
        if (v_r >= trial) begin
          v_nxt   = v_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (state_r == F_IDLE && start) begin
      dx_r   <= in_dir_x;
      dy_r   <= in_dir_y;
      sr_r   <= in_start_red;
      sg_r   <= in_start_green;
      sb_r   <= in_start_blue;
      er_r   <= in_end_red;
      eg_r   <= in_end_green;
      eb_r   <= in_end_blue;
      op_r   <= in_layer_opacity;
      sa_r   <= in_start_alpha;
      ea_r   <= in_end_alpha;
      comp_r <= compressed_mode;
    end
  end

  assign busy       = (state_r != F_IDLE);
  assign push_valid = (state_r == F_PUSH);

  always_comb begin
    push_item.num_a      = dx_e + dy_e;
    push_item.num_b      = dy_e - dx_e;
    push_item.divisor    = comp_r ? DivisorW'(l1) : res_r[DivisorW-1:0];
    push_item.compressed = comp_r;
    push_item.zero_dir   = zero_dir;
    push_item.s_red      = sr_r;
    push_item.s_green    = sg_r;
    push_item.s_blue     = sb_r;
    push_item.s_alpha    = zero_dir ? op_r : scale_alpha(sa_r, op_r);
    push_item.e_red      = er_r;
    push_item.e_green    = eg_r;
    push_item.e_blue     = eb_r;
    push_item.e_alpha    = scale_alpha(ea_r, op_r);
  end

endmodule

// ----- design/gcc_queue.sv -----
// Short queue of classified items between the front end and the back end.
// Depends on gcc_pkg for the item type.
`timescale 1ns / 1ps
module gcc_queue #(
  parameter int Depth = gcc_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gcc_pkg::gcc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output gcc_pkg::gcc_item_t pop_item,
  output logic               empty
);
  import gcc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  gcc_item_t entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_item = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
    if (do_push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

// ----- design/gcc_back.sv -----
// Back end: two bit-serial dividers give the corner weights, then one corner a cycle
// is blended through a two-stage multiply and add. Depends on gcc_pkg.
`timescale 1ns / 1ps
module gcc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  gcc_pkg::gcc_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [1:0]                  out_corner,
  output logic [gcc_pkg::ColorW-1:0]  out_red,
  output logic [gcc_pkg::ColorW-1:0]  out_green,
  output logic [gcc_pkg::ColorW-1:0]  out_blue,
  output logic [gcc_pkg::ColorW-1:0]  out_alpha,
  output logic                        out_last_corner
);
  import gcc_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;
  localparam int ProdW = ColorW + 1 + WeightW + 1;

  logic [1:0] state_r;
  logic [4:0] step_r;
  logic [1:0] corner_r;
  gcc_item_t item_r;
  logic [DivisorW-1:0] rem_a_r, rem_b_r;
  logic [QuotW-1:0] lo_a_r, lo_b_r, q_a_r, q_b_r;

  logic [NumW-1:0] mag_a, mag_b;
  logic [DividendW-1:0] n_a, n_b;
  logic [DivisorW:0] t_a, t_b;
  logic ge_a, ge_b;

  logic [QuotW-1:0] qc_a, qc_b, q_sel;
  logic neg_sel;
  logic [WeightW-1:0] w_cur;
  logic signed [ColorW:0] diff [4];
  logic [ColorW-1:0] s_ch [4];
  logic [ColorW-1:0] e_ch [4];

  logic p_valid_r;
  logic [1:0] p_corner_r;
  logic signed [ProdW-1:0] prod_r [4];
  logic [ColorW-1:0] p_e_r [4];
  logic [ColorW+3:0] chan [4];

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  // Dividend is |n| * 2^15 (L1 divisor) or |n| * 2^30 (root divisor).
  always_comb begin
    mag_a = q_item.num_a[NumW-1] ? NumW'(-q_item.num_a) : NumW'(q_item.num_a);
    mag_b = q_item.num_b[NumW-1] ? NumW'(-q_item.num_b) : NumW'(q_item.num_b);
    n_a = q_item.compressed ? {15'b0, mag_a, 15'b0} : {mag_a, 30'b0};
    n_b = q_item.compressed ? {15'b0, mag_b, 15'b0} : {mag_b, 30'b0};
  end

  assign t_a  = {rem_a_r, lo_a_r[QuotW-1]};
  assign t_b  = {rem_b_r, lo_b_r[QuotW-1]};
  assign ge_a = (t_a >= {1'b0, item_r.divisor});
  assign ge_b = (t_b >= {1'b0, item_r.divisor});

  assign qc_a = (q_a_r > OffsetMax) ? OffsetMax : q_a_r;
  assign qc_b = (q_b_r > OffsetMax) ? OffsetMax : q_b_r;

  // Corners 0 and 3 use dx+dy with opposite sign, corners 1 and 2 use dy-dx.
  always_comb begin
    unique case (corner_r)
      2'd0: begin q_sel = qc_a; neg_sel =  item_r.num_a[NumW-1]; end
      2'd1: begin q_sel = qc_b; neg_sel =  item_r.num_b[NumW-1]; end
      2'd2: begin q_sel = qc_b; neg_sel = !item_r.num_b[NumW-1]; end
      default: begin q_sel = qc_a; neg_sel = !item_r.num_a[NumW-1]; end
    endcase
    if (item_r.zero_dir)  w_cur = WeightFull;
    else if (neg_sel)     w_cur = WeightHalf - WeightW'(q_sel);
    else                  w_cur = WeightHalf + WeightW'(q_sel);
  end

  always_comb begin
    s_ch[0] = item_r.s_red;   e_ch[0] = item_r.e_red;
    s_ch[1] = item_r.s_green; e_ch[1] = item_r.e_green;
    s_ch[2] = item_r.s_blue;  e_ch[2] = item_r.e_blue;
    s_ch[3] = item_r.s_alpha; e_ch[3] = item_r.e_alpha;
    for (int i = 0; i < 4; i++) begin
      diff[i] = $signed({1'b0, s_ch[i]}) - $signed({1'b0, e_ch[i]});
      chan[i] = (ColorW+4)'($signed({4'b0, p_e_r[i]}) + (ColorW+4)'(prod_r[i] >>> 16));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      p_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid_r <= (state_r == B_EMIT);
      out_valid <= p_valid_r;
      unique case (state_r)
        B_IDLE: if (!q_empty) state_r <= q_item.zero_dir ? B_EMIT : B_DIV;
        B_DIV:  if (step_r == 5'(QuotW - 1)) state_r <= B_EMIT;
        B_EMIT: if (corner_r == 2'd3) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end

    unique case (state_r)
      B_IDLE: begin
        item_r   <= q_item;
        step_r   <= '0;
        corner_r <= '0;
        rem_a_r  <= DivisorW'(n_a[DividendW-1:QuotW]);
        rem_b_r  <= DivisorW'(n_b[DividendW-1:QuotW]);
        lo_a_r   <= n_a[QuotW-1:0];
        lo_b_r   <= n_b[QuotW-1:0];
      end
      B_DIV: begin
        step_r  <= step_r + 5'd1;
        rem_a_r <= ge_a ? DivisorW'(t_a - {1'b0, item_r.divisor}) : t_a[DivisorW-1:0];
        rem_b_r <= ge_b ? DivisorW'(t_b - {1'b0, item_r.divisor}) : t_b[DivisorW-1:0];
        lo_a_r  <= lo_a_r << 1;
        lo_b_r  <= lo_b_r << 1;
        q_a_r   <= {q_a_r[QuotW-2:0], ge_a};
        q_b_r   <= {q_b_r[QuotW-2:0], ge_b};
      end
      B_EMIT: corner_r <= corner_r + 2'd1;
      default: ;
    endcase

    p_corner_r <= corner_r;
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= ProdW'(diff[i]) * ProdW'($signed({1'b0, w_cur}));
      p_e_r[i]  <= e_ch[i];
    end

    out_corner      <= p_corner_r;
    out_last_corner <= p_valid_r && (p_corner_r == 2'd3);
    out_red         <= chan[0][ColorW-1:0];
    out_green       <= chan[1][ColorW-1:0];
    out_blue        <= chan[2][ColorW-1:0];
    out_alpha       <= chan[3][ColorW-1:0];
  end

endmodule

// ----- design/gradient_corner_colors_core.sv -----
// Top level of the gradient corner color block: configuration register, front end,
// item queue and back end. Depends on gcc_pkg, gcc_front, gcc_queue, gcc_back and assert_macros.svh.
//
// Usage: drive the in_ fields and raise start; the transfer happens at a clock edge
// where start is high and busy is low. Each input transfer produces four result
// transfers, corners (-1,-1), (1,-1), (-1,1), (1,1), each on the out_ ports for exactly
// one cycle with out_valid high and out_last_corner set on the fourth. The four
// corners of an item come on consecutive cycles. The receiver cannot stall;
// results are always taken in the cycle they are shown.
// The front end stays busy from an input transfer until its item is pushed; in compressed
// mode or for a zero direction it skips the root, otherwise its one-bit-per-cycle square
// root (32 steps) sets its pace; busy also stays high while the queue is full. The back
// end runs 18 divide steps shared by two dividers, then 4 corners, or only the 4 corners
// for a zero direction. With the queue between them the sustained rate is that of the
// slower of the two. cfg_wr_en writes compressed_mode, which resets to 1; it is sampled
// at each input transfer. A synchronous reset empties the queue and idles both ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gradient_corner_colors_core #(
  parameter int QUEUE_DEPTH = gcc_pkg::QueueDepth
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [gcc_pkg::DirW-1:0]  in_dir_x,
  input  logic signed [gcc_pkg::DirW-1:0]  in_dir_y,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_red,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_green,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_blue,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_red,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_green,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_blue,
  input  logic [gcc_pkg::ColorW-1:0]       in_layer_opacity,
  input  logic [gcc_pkg::ColorW-1:0]       in_start_alpha,
  input  logic [gcc_pkg::ColorW-1:0]       in_end_alpha,
  output logic                             out_valid,
  output logic [1:0]                       out_corner,
  output logic [gcc_pkg::ColorW-1:0]       out_red,
  output logic [gcc_pkg::ColorW-1:0]       out_green,
  output logic [gcc_pkg::ColorW-1:0]       out_blue,
  output logic [gcc_pkg::ColorW-1:0]       out_alpha,
  output logic                             out_last_corner
);
  import gcc_pkg::*;

  logic compressed_mode_r;
  logic push_valid, q_full, q_empty, q_pop;
  gcc_item_t push_item, pop_item;

  // The single configuration register; it defaults to compressed mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      compressed_mode_r <= cfg_wr_data;
    end
  end

  // Front end: one item at a time, parks the finished item until the queue has room.
  gcc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .compressed_mode  (compressed_mode_r),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_start_red     (in_start_red),
    .in_start_green   (in_start_green),
    .in_start_blue    (in_start_blue),
    .in_end_red       (in_end_red),
    .in_end_green     (in_end_green),
    .in_end_blue      (in_end_blue),
    .in_layer_opacity (in_layer_opacity),
    .in_start_alpha   (in_start_alpha),
    .in_end_alpha     (in_end_alpha),
    .push_valid       (push_valid),
    .push_ready       (!q_full),
    .push_item        (push_item)
  );

  // The queue lets the front end take the next transfer while the back end is still
  // emitting corners of an earlier one.
  gcc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // Back end: weights by division (none for a zero direction), then four blended corners on consecutive cycles.
  gcc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_corner      (out_corner),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_last_corner (out_last_corner)
  );

  `GCC_ASSERT(a_last_is_fourth, out_last_corner |-> (out_valid && out_corner == 2'd3), "last corner flag off corner three")
  `GCC_ASSERT(a_corners_in_row, (out_valid && out_corner != 2'd3) |=> (out_valid && out_corner == $past(out_corner) + 2'd1), "corner sequence broken")
  `GCC_ASSERT(a_busy_after_take, (start && !busy) |=> busy, "front end not busy after a transfer")
  `GCC_ASSERT_NEVER(a_pop_when_empty, q_pop && q_empty, "back end popped an empty queue")

endmodule

// ----- verif/gradient_corner_colors_core_tb.sv -----
// Self-checking testbench for gradient_corner_colors_core: random and directed gradients,
// predicted corner colors compared field by field. Depends on gcc_pkg and the core RTL.
`timescale 1ns / 1ps
module gradient_corner_colors_core_tb;
  import gcc_pkg::*;

  // One gradient request as presented on the in_ ports.
  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0] s_r, s_g, s_b, e_r, e_g, e_b, opacity, s_a, e_a;
  } grad_req_t;

  // One corner color as it should appear on the out_ ports.
  typedef struct {
    logic [1:0] corner;
    logic [7:0] r, g, b, a;
    logic last;
  } corner_color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0;
  logic [7:0] in_start_red = '0, in_start_green = '0, in_start_blue = '0;
  logic [7:0] in_end_red = '0, in_end_green = '0, in_end_blue = '0;
  logic [7:0] in_layer_opacity = '0, in_start_alpha = '0, in_end_alpha = '0;
  logic out_valid, out_last_corner;
  logic [1:0] out_corner;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  grad_req_t pending_reqs[$];
  corner_color_t expected_corners[$];
  bit mode_compressed = 1'b1;  // mirror of the block's register
  int fail_count = 0;
  bit hold_sender = 1'b0;     // set by the stimulus to let the block drain
  int burst_left = 0;
  int gap_left = 0;

  always #10 clk = ~clk;

  gradient_corner_colors_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y),
    .in_start_red(in_start_red), .in_start_green(in_start_green),
    .in_start_blue(in_start_blue), .in_end_red(in_end_red),
    .in_end_green(in_end_green), .in_end_blue(in_end_blue),
    .in_layer_opacity(in_layer_opacity), .in_start_alpha(in_start_alpha),
    .in_end_alpha(in_end_alpha),
    .out_valid(out_valid), .out_corner(out_corner), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
    .out_last_corner(out_last_corner)
  );

  // Bitwise integer square root, floor of sqrt(v).
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] mix(input longint s, input longint e, input longint w);
    return 8'(((e * (65536 - w)) + s * w) >>> 16);
  endfunction

  // Works out the four corner colors of a request and queues them.
  task automatic predict_corners(input grad_req_t q);
    longint dx, dy, n, off, den, w, sa, ea, sq;
    corner_color_t c;
    dx = q.dx;
    dy = q.dy;
    sa = (q.s_a * q.opacity) / 255;
    ea = (q.e_a * q.opacity) / 255;
    for (int k = 0; k < 4; k++) begin
      c.corner = 2'(k);
      c.last = (k == 3);
      if (dx == 0 && dy == 0) begin
        c.r = q.s_r; c.g = q.s_g; c.b = q.s_b; c.a = q.opacity;
      end else begin
        n = ((k & 1) ? -dx : dx) + ((k & 2) ? -dy : dy);
        if (mode_compressed) begin
          den = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
          off = (n * 32768) / den;
        end else begin
          sq = dx * dx + dy * dy;
          den = longint'(isqrt(longint'(sq) << 31));
          off = (n * (64'sd1 <<< 30)) / den;
        end
        if (off > 32768) off = 32768;
        if (off < -32768) off = -32768;
        w = 32768 + off;
        c.r = mix(q.s_r, q.e_r, w);
        c.g = mix(q.s_g, q.e_g, w);
        c.b = mix(q.s_b, q.e_b, w);
        c.a = mix(sa, ea, w);
      end
      expected_corners.push_back(c);
    end
  endtask

  // Driver: bursts of back-to-back requests separated by random gaps. The request on
  // the ports is always the front of the pending queue; it leaves the queue when taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_corners(pending_reqs.pop_front());
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          in_dir_x <= pending_reqs[0].dx;
          in_dir_y <= pending_reqs[0].dy;
          in_start_red <= pending_reqs[0].s_r;
          in_start_green <= pending_reqs[0].s_g;
          in_start_blue <= pending_reqs[0].s_b;
          in_end_red <= pending_reqs[0].e_r;
          in_end_green <= pending_reqs[0].e_g;
          in_end_blue <= pending_reqs[0].e_b;
          in_layer_opacity <= pending_reqs[0].opacity;
          in_start_alpha <= pending_reqs[0].s_a;
          in_end_alpha <= pending_reqs[0].e_a;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 5);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed corner is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_corners.size() == 0) begin
        $error("unexpected corner %0d", out_corner);
        fail_count++;
      end else begin
        automatic corner_color_t c = expected_corners.pop_front();
        if (out_corner !== c.corner) begin
          $error("corner: expected %0d, got %0d", c.corner, out_corner); fail_count++;
        end
        if (out_red !== c.r) begin
          $error("red: expected %0d, got %0d", c.r, out_red); fail_count++;
        end
        if (out_green !== c.g) begin
          $error("green: expected %0d, got %0d", c.g, out_green); fail_count++;
        end
        if (out_blue !== c.b) begin
          $error("blue: expected %0d, got %0d", c.b, out_blue); fail_count++;
        end
        if (out_alpha !== c.a) begin
          $error("alpha: expected %0d, got %0d", c.a, out_alpha); fail_count++;
        end
        if (out_last_corner !== c.last) begin
          $error("last_corner: expected %0d, got %0d", c.last, out_last_corner);
          fail_count++;
        end
      end
    end
  end

  function automatic grad_req_t make_req(input int dx, input int dy, input bit rnd_colors);
    grad_req_t q;
    q.dx = 16'(dx);
    q.dy = 16'(dy);
    q.s_r = rnd_colors ? 8'($urandom) : 8'hff;
    q.s_g = rnd_colors ? 8'($urandom) : 8'h00;
    q.s_b = rnd_colors ? 8'($urandom) : 8'hff;
    q.e_r = rnd_colors ? 8'($urandom) : 8'h00;
    q.e_g = rnd_colors ? 8'($urandom) : 8'hff;
    q.e_b = rnd_colors ? 8'($urandom) : 8'h00;
    q.opacity = rnd_colors ? 8'($urandom) : 8'hff;
    q.s_a = rnd_colors ? 8'($urandom) : 8'hff;
    q.e_a = rnd_colors ? 8'($urandom) : 8'h00;
    return q;
  endfunction

  // Random direction: mostly full range, sometimes small or axis-aligned.
  function automatic int rand_dir();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $signed(16'($urandom_range(0, 8))) - 4;
      2: return ($urandom_range(0, 1)) ? 32767 : -32768;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // Waits until every queued request has gone in and every corner has come out,
  // then lets the back end settle before the register may change.
  task automatic drain();
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_corners.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_compressed = m;
  endtask

  initial begin
    grad_req_t q;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, axis directions and the zero-vector case, in both modes.
    for (int m = 0; m < 2; m++) begin
      write_mode(m[0]);
      pending_reqs.push_back(make_req(0, 0, 0));
      pending_reqs.push_back(make_req(0, 0, 1));
      pending_reqs.push_back(make_req(256, 0, 0));
      pending_reqs.push_back(make_req(0, -256, 0));
      pending_reqs.push_back(make_req(32767, 32767, 0));
      pending_reqs.push_back(make_req(-32768, -32768, 1));
      pending_reqs.push_back(make_req(-32768, 32767, 1));
      pending_reqs.push_back(make_req(1, -1, 1));
      pending_reqs.push_back(make_req(3, 0, 1));
      q = make_req(100, 37, 0);
      q.opacity = 8'd0;
      pending_reqs.push_back(q);
      q = make_req(-5, 200, 1);
      q.s_a = 8'hff; q.e_a = 8'hff; q.opacity = 8'd128;
      pending_reqs.push_back(q);
      drain();
    end
    // Random phases, switching the mode between them, with a full drain pause.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph == 5 ? 1'b1 : 1'($urandom));
      for (int i = 0; i < 34; i++)
        pending_reqs.push_back(make_req(rand_dir(), rand_dir(), 1));
      if (ph == 2) begin
        wait (pending_reqs.size() < 17);
        hold_sender = 1'b1;
        wait (expected_corners.size() == 0 && !start);
        hold_sender = 1'b0;
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
